### rtl/core/lsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg - shared types and constants for the line syllable counter
// Character codes, default widths and the per-word tracking record.
// ----------------------------------------------------------------------------
package lsc_pkg;

	localparam int SUM_BITS_DEF        = 12;
	localparam int LINE_INDEX_BITS_DEF = 16;

	localparam logic [7:0] CHAR_A       = 8'h61;
	localparam logic [7:0] CHAR_E       = 8'h65;
	localparam logic [7:0] CHAR_I       = 8'h69;
	localparam logic [7:0] CHAR_O       = 8'h6F;
	localparam logic [7:0] CHAR_U       = 8'h75;
	localparam logic [7:0] CHAR_Z       = 8'h7A;
	localparam logic [7:0] CHAR_APOS    = 8'h27;
	localparam logic [7:0] CHAR_NL      = 8'h0A;
	localparam logic [7:0] CASE_BIT     = 8'h20;
	localparam logic [1:0] SHORT_WORD   = 2'd2;
	localparam logic [7:0] SYL_MAX      = 8'hFF;

	typedef struct packed {
		logic       in_word;
		logic       after_vowel;
		logic [7:0] syl;
		logic [1:0] len;
		logic       last_e;
		logic       before_last_vowel;
	} word_state_t;

	function automatic logic vowel_char(input logic [7:0] c);
		return (c == CHAR_A) || (c == CHAR_E) || (c == CHAR_I) || (c == CHAR_O) ||
			(c == CHAR_U);
	endfunction

	// Syllables a finished word contributes: silent-e rule, floor of one
	function automatic logic [7:0] word_credit(input word_state_t w);
		logic [7:0] s;
		s = w.syl;
		if ((w.len > SHORT_WORD) && w.last_e && !w.before_last_vowel && (s > 8'd1)) begin
			s = s - 8'd1;
		end
		if (s == 8'd0) begin
			s = 8'd1;
		end
		return s;
	endfunction

endpackage

### rtl/core/line_syllable_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_syllable_counter - heuristic syllable count per line of text
// Byte stream in, one transaction out for every non-empty line.
// ----------------------------------------------------------------------------
// One byte per clock is taken on the slave side while results are taken; tlast
// marks the final byte of the text and closes any open line. Each byte sits in
// one input register and is folded into the word and line counters as it leaves
// it, so m_tvalid for a closed line rises when its closing byte moves from the
// input register into the result register. Throughput is one byte every cycle
// while the master side takes results; a stalled result register holds one byte
// in the input stage and then drops s_tready. Newlines ending an empty line give
// no transaction. The syllable sum and the line index saturate at their full
// width.
module line_syllable_counter #(
	parameter int SUM_BITS        = lsc_pkg::SUM_BITS_DEF,
	parameter int LINE_INDEX_BITS = lsc_pkg::LINE_INDEX_BITS_DEF,
	localparam int OUT_W = ((SUM_BITS + LINE_INDEX_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // [7:0] text_byte
	input  logic             s_tlast,  // is_last
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // line_syllables, line index, zero pad
);

	localparam logic [SUM_BITS-1:0]        SUM_MAX = '1;
	localparam logic [LINE_INDEX_BITS-1:0] IDX_MAX = '1;

	logic                       valid_s1;
	logic [7:0]                 byte_s1;
	logic                       last_s1;
	logic                       out_valid_s2;
	logic [SUM_BITS-1:0]        sum_s2;
	logic [LINE_INDEX_BITS-1:0] num_s2;

	lsc_pkg::word_state_t       word_q;
	logic                       line_open_q;
	logic [SUM_BITS-1:0]        line_sum_q;
	logic [LINE_INDEX_BITS-1:0] line_count_q;

	logic                       adv;
	logic                       is_nl, is_alpha, is_apos, take, vowel, close_line;
	logic [7:0]                 fold, ch;
	lsc_pkg::word_state_t       w_taken, w_src, w_next;
	logic                       do_close_word;
	logic [SUM_BITS:0]          sum_wide;
	logic [SUM_BITS-1:0]        sum_new;
	logic                       emit;

	assign adv      = valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_comb begin
		is_nl    = (byte_s1 == lsc_pkg::CHAR_NL);
		fold     = byte_s1 | lsc_pkg::CASE_BIT;
		is_alpha = fold inside {[lsc_pkg::CHAR_A:lsc_pkg::CHAR_Z]};
		is_apos  = (byte_s1 == lsc_pkg::CHAR_APOS);
		take     = !is_nl && (is_alpha || is_apos);
		ch       = is_alpha ? fold : byte_s1;
		vowel    = lsc_pkg::vowel_char(ch);

		w_taken                   = word_q;
		w_taken.in_word           = 1'b1;
		w_taken.before_last_vowel = word_q.after_vowel;
		w_taken.after_vowel       = vowel;
		w_taken.last_e            = (ch == lsc_pkg::CHAR_E);
		if (vowel && !word_q.after_vowel && (word_q.syl != lsc_pkg::SYL_MAX)) begin
			w_taken.syl = word_q.syl + 8'd1;
		end
		if (word_q.len != 2'd3) begin
			w_taken.len = word_q.len + 2'd1;
		end

		close_line = is_nl || last_s1;
		// a letter or apostrophe closes its word only when it is the final byte
		do_close_word = take ? last_s1 : 1'b1;
		w_src         = take ? w_taken : word_q;

		sum_wide = {1'b0, line_sum_q} + (SUM_BITS+1)'(lsc_pkg::word_credit(w_src));
		if (do_close_word && w_src.in_word) begin
			sum_new = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
		end else begin
			sum_new = line_sum_q;
		end

		w_next = (take && !last_s1) ? w_taken : '0;
		emit   = close_line && (is_nl ? line_open_q : 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q       <= '0;
			line_open_q  <= 1'b0;
			line_sum_q   <= '0;
			line_count_q <= '0;
		end else if (adv) begin
			word_q      <= w_next;
			line_open_q <= !close_line;
			line_sum_q  <= close_line ? '0 : sum_new;
			if (emit && (line_count_q != IDX_MAX)) begin
				line_count_q <= line_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= emit;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			sum_s2 <= sum_new;
			num_s2 <= line_count_q;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = OUT_W'({num_s2, sum_s2});

endmodule

### rtl/core/lsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_checker - port-level checks for the line syllable counter
// Watches handshakes, line numbering and the idle state after reset; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lsc_checker #(
	parameter int SUM_BITS        = lsc_pkg::SUM_BITS_DEF,
	parameter int LINE_INDEX_BITS = lsc_pkg::LINE_INDEX_BITS_DEF,
	localparam int OUT_W = ((SUM_BITS + LINE_INDEX_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [7:0]       s_tdata,
	input logic             s_tlast,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam logic [LINE_INDEX_BITS-1:0] IDX_MAX = '1;

	logic [LINE_INDEX_BITS-1:0] expect_num_q;
	logic                       m_xfer;
	logic                       s_xfer;

	assign m_xfer = m_tvalid && m_tready;
	assign s_xfer = s_tvalid && s_tready;

	// track the line index the next result transaction should carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_num_q <= '0;
		end else if (m_xfer && (expect_num_q != IDX_MAX)) begin
			expect_num_q <= expect_num_q + 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
		else $error("input transaction changed while waiting");

	a_line_number: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer |-> m_tdata[SUM_BITS +: LINE_INDEX_BITS] == expect_num_q)
		else $error("line number out of sequence");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a stalled result");

	a_idle_after_reset: assert property (@(posedge clk)
		$past(!arst_n) |-> !m_tvalid && !$past(s_xfer))
		else $error("result present straight after reset");

endmodule

bind line_syllable_counter lsc_checker #(
	.SUM_BITS        (SUM_BITS),
	.LINE_INDEX_BITS (LINE_INDEX_BITS)
) u_lsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
